FILE: rtl/core/ir90_pkg.sv
// Package for the 90-degree frame rotation engine: sizes, codes and item types.
package ir90_pkg;

  // Largest frame side and depth of the frame store
  localparam int MAX_DIM     = 256;
  localparam int FRAME_DEPTH = 65536;

  // Derived widths
  localparam int CFG_W = 9;                                  // config register width
  localparam int DIM_W = $clog2(MAX_DIM + 1);                // clamped dimension
  localparam int POS_W = $clog2(MAX_DIM);                    // output row / column
  localparam int TOT_W = $clog2(MAX_DIM * MAX_DIM + 1);      // pixel count, raster index
  localparam int AW    = $clog2(FRAME_DEPTH);                // frame store address
  localparam int PIX_W = 24;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Input item
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       out_valid;
    logic       out_last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // store one pixel
    logic read;    // fetch from a full frame
    logic blank;   // fetch before the frame is full
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_full;
  } stat_t;

endpackage

FILE: rtl/core/ir90_ctrl.sv
// Controller for the rotation engine: accepts items and sequences the result cycle.
module ir90_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            req_type,
  input  ir90_pkg::stat_t stat,
  output ir90_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state;
  logic state_next;
  logic take;

  assign take = start && (state == S_IDLE);

  // Command decode
  always_comb begin
    cmd.load  = take && (req_type == ir90_pkg::REQ_LOAD);
    cmd.read  = take && (req_type == ir90_pkg::REQ_FETCH) && stat.frame_full;
    cmd.blank = take && (req_type == ir90_pkg::REQ_FETCH) && !stat.frame_full;
  end

  // Next state: an accepted fetch enters S_RESP to present its result, then returns to S_IDLE
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.read || cmd.blank) state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

FILE: rtl/core/ir90_datapath.sv
// Datapath for the rotation engine: config registers, counters, frame store, result register.
module ir90_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ir90_pkg::CFG_W-1:0]   cfg_data,
  input  ir90_pkg::in_t                req,
  input  ir90_pkg::cmd_t               cmd,
  output ir90_pkg::stat_t              stat,
  output ir90_pkg::out_t               result
);

  localparam int DIM_W = ir90_pkg::DIM_W;
  localparam int POS_W = ir90_pkg::POS_W;
  localparam int TOT_W = ir90_pkg::TOT_W;
  localparam int AW    = ir90_pkg::AW;
  localparam int PIX_W = ir90_pkg::PIX_W;

  // Zero reads as one, anything above the largest side reads as the largest side
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [ir90_pkg::CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > 32'(ir90_pkg::MAX_DIM)) r = DIM_W'(ir90_pkg::MAX_DIM);
    else r = DIM_W'(v);
    return r;
  endfunction

  logic [ir90_pkg::CFG_W-1:0] image_width;
  logic [ir90_pkg::CFG_W-1:0] image_height;

  logic [TOT_W-1:0] load_count;
  logic             frame_full;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;

  logic [PIX_W-1:0] frame_store [ir90_pkg::FRAME_DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic             res_zero;
  logic             res_valid;
  logic             res_last;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] count_inc;
  logic             count_room;
  logic             store_en;
  logic             outside;
  logic             last;
  logic [TOT_W-1:0] src;
  logic             src_hit;
  logic [POS_W:0]   col_inc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ir90_pkg::CFG_W'(256);
      image_height <= ir90_pkg::CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ir90_pkg::REG_WIDTH:  image_width  <= cfg_data;
        ir90_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame size and load bookkeeping
  assign w          = clamp_dim(image_width);
  assign h          = clamp_dim(image_height);
  assign total      = TOT_W'(w * h);
  assign count_room = (load_count < total);
  assign count_inc  = load_count + TOT_W'(1);
  assign store_en   = cmd.load && !frame_full && count_room
                      && (32'(load_count) < 32'(ir90_pkg::FRAME_DEPTH));

  // Readout position: source column w-1-row of source row col
  assign outside = (DIM_W'(out_row) >= w) || (DIM_W'(out_col) >= h);
  assign src     = TOT_W'(out_col * w) + TOT_W'(w - DIM_W'(1) - DIM_W'(out_row));
  assign src_hit = (32'(src) < 32'(ir90_pkg::FRAME_DEPTH));
  assign last    = outside || ((DIM_W'(out_row) == w - DIM_W'(1))
                               && (DIM_W'(out_col) == h - DIM_W'(1)));
  assign col_inc = {1'b0, out_col} + (POS_W+1)'(1);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      frame_full <= 1'b0;
      out_row    <= '0;
      out_col    <= '0;
    end else if (cmd.load && !frame_full) begin
      if (count_room) begin
        load_count <= count_inc;
        if (count_inc >= total) frame_full <= 1'b1;
      end else begin
        frame_full <= 1'b1;
      end
    end else if (cmd.read) begin
      if (last) begin
        load_count <= '0;
        frame_full <= 1'b0;
        out_row    <= '0;
        out_col    <= '0;
      end else if (DIM_W'(col_inc) >= h) begin
        out_col <= '0;
        out_row <= out_row + POS_W'(1);
      end else begin
        out_col <= POS_W'(col_inc);
      end
    end
  end

  // Frame store: one write port for loads, registered read for fetches
  always_ff @(posedge clk) begin
    if (store_en) frame_store[AW'(load_count)] <= {req.in_red, req.in_green, req.in_blue};
    if (cmd.read) rd_data <= frame_store[AW'(src)];
  end

  // Result flags, held for the result cycle
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      res_zero  <= outside || !src_hit;
      res_valid <= 1'b1;
      res_last  <= last;
    end else if (cmd.blank) begin
      res_zero  <= 1'b1;
      res_valid <= 1'b0;
      res_last  <= 1'b0;
    end
  end

  // Result item
  always_comb begin
    result.out_blue  = res_zero ? 8'd0 : rd_data[7:0];
    result.out_green = res_zero ? 8'd0 : rd_data[15:8];
    result.out_red   = res_zero ? 8'd0 : rd_data[23:16];
    result.out_valid = res_valid;
    result.out_last  = res_last;
  end

  assign stat.frame_full = frame_full;

endmodule

FILE: rtl/core/image_rotate_90.sv
// Top level of the 90-degree frame rotation engine.
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------
//  request  | start, busy, req                 | accepted when start && !busy
//  result   | done, result                     | valid for the one cycle done=1
//  config   | cfg_we, cfg_index, cfg_data      | written when cfg_we=1
//
// A load item is accepted without raising busy, so loads can stream at one a clock.
// A fetch item is not done at acceptance: the frame store's registered read port puts the
// pixel out in the cycle after acceptance, and busy is high during that result cycle.
// Synchronous active-high reset clears the counters and sets both dimensions to 256;
// the frame store is not cleared. The receiver cannot stall, so results never wait.
module image_rotate_90 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ir90_pkg::in_t              req,
  output logic                       done,
  output ir90_pkg::out_t             result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [ir90_pkg::CFG_W-1:0] cfg_data
);

  ir90_pkg::cmd_t  cmd;
  ir90_pkg::stat_t stat;

  ir90_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  ir90_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  // A result only follows an accepted fetch
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (req.req_type == ir90_pkg::REQ_FETCH)))
    else $error("result without a fetch");

  // Results come one per fetch, never two in a row
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("repeated result");

  // A blank answer carries no pixel and no last flag
  assert property (@(posedge clk) disable iff (rst)
    (done && !result.out_valid) |-> (result.out_blue == 8'd0 && result.out_green == 8'd0
      && result.out_red == 8'd0 && !result.out_last))
    else $error("blank result carries data");

  // No command reaches the datapath during the result cycle
  assert property (@(posedge clk) disable iff (rst)
    busy |-> !(cmd.load || cmd.read || cmd.blank))
    else $error("command issued while busy");

endmodule

FILE: verif/tb_image_rotate_90.sv
// Testbench for image_rotate_90: frame load, rotated readout and register corner cases.
module tb_image_rotate_90;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = $bits(ir90_pkg::in_t);

  // Tracks the loaded frame and readout position, predicts each fetched pixel
  class rotated_pixel_tracker;
    bit [ir90_pkg::PIX_W-1:0] source_frame [ir90_pkg::FRAME_DEPTH];
    bit [ir90_pkg::CFG_W-1:0] width_reg;
    bit [ir90_pkg::CFG_W-1:0] height_reg;
    int unsigned              loaded;
    int unsigned              out_row;
    int unsigned              out_col;
    bit                       full;
    ir90_pkg::out_t           expected_pixels [$];
    int                       errors;

    function new();
      width_reg  = ir90_pkg::CFG_W'(ir90_pkg::MAX_DIM);
      height_reg = ir90_pkg::CFG_W'(ir90_pkg::MAX_DIM);
      restart();
    endfunction

    // 0 acts as 1, anything above the largest side acts as the largest side
    function int unsigned side(bit [ir90_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > ir90_pkg::MAX_DIM) return ir90_pkg::MAX_DIM;
      return 32'(v);
    endfunction

    function void restart();
      loaded  = 0;
      full    = 1'b0;
      out_row = 0;
      out_col = 0;
    endfunction

    function void write_reg(logic idx, bit [ir90_pkg::CFG_W-1:0] v);
      if (idx == ir90_pkg::REG_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    // Called once per accepted item
    function void note_request(ir90_pkg::in_t it);
      int unsigned              w;
      int unsigned              h;
      int unsigned              total;
      int unsigned              src;
      bit [ir90_pkg::PIX_W-1:0] px;
      ir90_pkg::out_t           want;
      w     = side(width_reg);
      h     = side(height_reg);
      total = w * h;
      want  = '0;
      if (it.req_type == ir90_pkg::REQ_LOAD) begin
        // loads into a full frame are dropped
        if (!full) begin
          if (loaded < total) begin
            if (loaded < ir90_pkg::FRAME_DEPTH)
              source_frame[ir90_pkg::AW'(loaded)] = {it.in_red, it.in_green, it.in_blue};
            loaded++;
          end
          if (loaded >= total) full = 1'b1;
        end
        return;
      end
      // fetch before the frame is full answers an all-zero, invalid pixel
      if (full) begin
        px = '0;
        want.out_valid = 1'b1;
        if (out_row >= w || out_col >= h) begin
          // position fell outside shrunken dimensions: end the frame
          want.out_last = 1'b1;
        end else begin
          src = out_col * w + (w - 1 - out_row);
          if (src < ir90_pkg::FRAME_DEPTH) px = source_frame[ir90_pkg::AW'(src)];
          want.out_last = (out_row == w - 1) && (out_col == h - 1);
        end
        {want.out_red, want.out_green, want.out_blue} = px;
        if (want.out_last) begin
          restart();
        end else begin
          out_col++;
          if (out_col >= h) begin
            out_col = 0;
            out_row++;
          end
        end
      end
      expected_pixels.push_back(want);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_pixel(ir90_pkg::out_t got);
      ir90_pkg::out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %h", $time, got);
        return;
      end
      want = expected_pixels.pop_front();
      compare("out_blue", want.out_blue, got.out_blue);
      compare("out_green", want.out_green, got.out_green);
      compare("out_red", want.out_red, got.out_red);
      compare("out_valid", 8'(want.out_valid), 8'(got.out_valid));
      compare("out_last", 8'(want.out_last), 8'(got.out_last));
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  ir90_pkg::in_t              req;
  logic                       done;
  ir90_pkg::out_t             result;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [ir90_pkg::CFG_W-1:0] cfg_data;

  rotated_pixel_tracker tracker;
  int unsigned          gap_pct;

  image_rotate_90 DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result monitor: each result lives for exactly one cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_pixel(result);
  end

  // Idle cycles with junk on the request bus
  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      req   <= ir90_pkg::in_t'(IN_W'($urandom));
    end
  endtask

  // Offer one item and wait for it to be taken
  task automatic send(ir90_pkg::in_t it);
    if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) idle($urandom_range(3, 1));
    @(negedge clk);
    start <= 1'b1;
    req   <= it;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(it);
  endtask

  task automatic load_px(logic [ir90_pkg::PIX_W-1:0] rgb);
    ir90_pkg::in_t it;
    it.req_type = ir90_pkg::REQ_LOAD;
    {it.in_red, it.in_green, it.in_blue} = rgb;
    send(it);
  endtask

  task automatic fetch_px();
    ir90_pkg::in_t it;
    it = ir90_pkg::in_t'(IN_W'($urandom));
    it.req_type = ir90_pkg::REQ_FETCH;
    send(it);
  endtask

  // Drop start, wait for all pending pixels, then idle before returning
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ir90_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    tracker.write_reg(idx, v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_index <= 1'($urandom);
    cfg_data  <= ir90_pkg::CFG_W'($urandom);
  endtask

  // Mostly small sides, some zero, some above the limit, some large
  function automatic logic [ir90_pkg::CFG_W-1:0] pick_side();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 80) return ir90_pkg::CFG_W'($urandom_range(8, 1));
    if (r < 88) return '0;
    if (r < 94) return ir90_pkg::CFG_W'($urandom_range(511, 257));
    return ir90_pkg::CFG_W'($urandom_range(256, 9));
  endfunction

  initial begin
    int unsigned                counted;
    int unsigned                budget;
    int unsigned                phase;
    int unsigned                pick;
    bit                         do_fetch;
    logic [ir90_pkg::CFG_W-1:0] side_val;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    gap_pct   = 0;
    tracker   = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fetch before any frame is loaded
    fetch_px();
    // Small 4 x 3 frame with all-zero and all-one pixels at the start
    settle();
    write_reg(ir90_pkg::REG_WIDTH, 4);
    write_reg(ir90_pkg::REG_HEIGHT, 3);
    for (int i = 0; i < 12; i++) begin
      if (i == 0) load_px('0);
      else if (i == 1) load_px('1);
      else load_px(ir90_pkg::PIX_W'($urandom));
    end
    // Loads into a full frame are dropped
    load_px(ir90_pkg::PIX_W'($urandom));
    load_px(ir90_pkg::PIX_W'($urandom));
    repeat (2) fetch_px();
    // Shrink height under the readout position: ends the frame early
    settle();
    write_reg(ir90_pkg::REG_HEIGHT, 2);
    fetch_px();
    // Shrink the frame below the loaded count: next load marks it full
    settle();
    write_reg(ir90_pkg::REG_WIDTH, 3);
    write_reg(ir90_pkg::REG_HEIGHT, 3);
    repeat (6) load_px(ir90_pkg::PIX_W'($urandom));
    settle();
    write_reg(ir90_pkg::REG_WIDTH, 2);
    write_reg(ir90_pkg::REG_HEIGHT, 2);
    load_px(ir90_pkg::PIX_W'($urandom));
    repeat (4) fetch_px();
    // Zero sides act as one: single-pixel frame
    settle();
    write_reg(ir90_pkg::REG_WIDTH, 0);
    write_reg(ir90_pkg::REG_HEIGHT, 0);
    load_px(ir90_pkg::PIX_W'($urandom));
    fetch_px();

    // Random phases: mostly well-formed frames, a few stray fetches and loads.
    // A phase may stop mid-frame so the next size change lands on live state.
    // During readout sides only shrink, so no fetch reads a pixel that was never loaded.
    counted = 0;
    phase   = 0;
    while (counted < 1000) begin
      settle();
      case (phase % 4)
        1: gap_pct = 45;
        2: gap_pct = 38;
        default: gap_pct = 0;
      endcase
      pick = $urandom_range(2, 0);
      if (pick != 1) begin
        side_val = pick_side();
        if (tracker.full && tracker.side(side_val) > tracker.side(tracker.width_reg))
          side_val = tracker.width_reg;
        write_reg(ir90_pkg::REG_WIDTH, side_val);
      end
      if (pick != 0) begin
        side_val = pick_side();
        if (tracker.full && tracker.side(side_val) > tracker.side(tracker.height_reg))
          side_val = tracker.height_reg;
        write_reg(ir90_pkg::REG_HEIGHT, side_val);
      end
      budget = $urandom_range(200, 60);
      repeat (budget) begin
        do_fetch = tracker.full ^ ($urandom_range(99, 0) < 8);
        if (do_fetch || !tracker.full) counted++;
        if (do_fetch) fetch_px();
        else load_px(ir90_pkg::PIX_W'($urandom));
      end
      phase++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ir90_pkg.sv
rtl/core/ir90_ctrl.sv
rtl/core/ir90_datapath.sv
rtl/core/image_rotate_90.sv
verif/tb_image_rotate_90.sv
